### src/rmas_pkg.sv
// Shared types, opcodes and constants of the register machine ALU step.
package rmas_pkg;

  // Default size of the register file
  localparam int REG_COUNT_DEF = 32;

  // Field widths fixed by the instruction format
  localparam int OP_W   = 4;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;

  // Decoded operations
  typedef enum logic [OP_W-1:0] {
    OP_IN   = 4'd0,
    OP_OUT  = 4'd1,
    OP_MOV  = 4'd2,
    OP_XCHG = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11
  } op_t;

  // Input word: one decoded instruction
  typedef struct packed {
    logic [OP_W-1:0]          req_type;
    logic [IDX_W-1:0]         dest_index;
    logic [IDX_W-1:0]         src_index;
    logic signed [DATA_W-1:0] immediate;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     div_by_zero;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch instruction, read both operands
    logic exec;       // register the ALU result
    logic div_start;  // launch the divider
    logic div_take;   // register the divider result
    logic emit_out;   // strobe a register value
    logic emit_err;   // strobe a zero-divisor error
    logic wr_dest;    // write result to the destination
    logic wr_src;     // write old destination to the source (xchg)
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            b_zero;
    logic            div_done;
  } dp_status_t;

endpackage

### src/rmas_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
module rmas_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       want_mod,
  input  logic [rmas_pkg::DATA_W-1:0] dividend,
  input  logic [rmas_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [rmas_pkg::DATA_W-1:0] result
);
  import rmas_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] mb_r;
  logic              neg_q_r;
  logic              neg_r_r;
  logic              mod_r;

  logic              na;
  logic              nb;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              take;
  logic [DATA_W-1:0] rem_nxt;

  assign na = dividend[DATA_W-1];
  assign nb = divisor[DATA_W-1];

  // One trial subtraction per step
  assign shifted = {rem_r, q_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, mb_r};
  assign take    = ~diff[DATA_W];
  assign rem_nxt = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DATA_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Magnitudes, partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      q_r     <= na ? (DATA_W'(0) - dividend) : dividend;
      mb_r    <= nb ? (DATA_W'(0) - divisor) : divisor;
      rem_r   <= '0;
      neg_q_r <= na ^ nb;
      neg_r_r <= na;
      mod_r   <= want_mod;
    end else if (run_r) begin
      q_r   <= {q_r[DATA_W-2:0], take};
      rem_r <= rem_nxt;
    end
  end

  // Sign fix-up: quotient by both signs, remainder by the dividend's
  always_comb begin
    if (mod_r) begin
      result = neg_r_r ? (DATA_W'(0) - rem_r) : rem_r;
    end else begin
      result = neg_q_r ? (DATA_W'(0) - q_r) : q_r;
    end
  end

  assign done = done_r;

endmodule

### src/rmas_dp.sv
// Datapath: register file memory, ALU, divider and result register.
module rmas_dp #(
  parameter int REG_COUNT = rmas_pkg::REG_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmas_pkg::in_word_t     in_word,
  input  rmas_pkg::ctrl_cmd_t    cmd,
  output rmas_pkg::dp_status_t   sts,
  output logic                   out_valid,
  output rmas_pkg::out_word_t    out_word
);
  import rmas_pkg::*;

  localparam int AW = $clog2(REG_COUNT);

  // Register file storage and per-entry valid bits
  logic [DATA_W-1:0]    rf_mem_r [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  in_word_t          instr_r;
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;
  logic              va_r;
  logic              vb_r;
  logic [DATA_W-1:0] res_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [IDX_W+AW-1:0] rd_d_ext;
  logic [IDX_W+AW-1:0] rd_s_ext;
  logic [IDX_W+AW-1:0] wr_d_ext;
  logic [IDX_W+AW-1:0] wr_s_ext;
  logic [AW-1:0]       rd_d_addr;
  logic [AW-1:0]       rd_s_addr;
  logic [AW-1:0]       wr_d_addr;
  logic [AW-1:0]       wr_s_addr;
  logic                rd_d_in;
  logic                rd_s_in;
  logic                wr_d_in;
  logic                wr_s_in;

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] alu_nxt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              div_done;
  logic [DATA_W-1:0] div_result;

  // Index to address mapping; an index past the file is out of range
  assign rd_d_ext  = {AW'(0), in_word.dest_index};
  assign rd_s_ext  = {AW'(0), in_word.src_index};
  assign wr_d_ext  = {AW'(0), instr_r.dest_index};
  assign wr_s_ext  = {AW'(0), instr_r.src_index};
  assign rd_d_addr = rd_d_ext[AW-1:0];
  assign rd_s_addr = rd_s_ext[AW-1:0];
  assign wr_d_addr = wr_d_ext[AW-1:0];
  assign wr_s_addr = wr_s_ext[AW-1:0];
  assign rd_d_in   = int'(in_word.dest_index) < REG_COUNT;
  assign rd_s_in   = int'(in_word.src_index) < REG_COUNT;
  assign wr_d_in   = int'(instr_r.dest_index) < REG_COUNT;
  assign wr_s_in   = int'(instr_r.src_index) < REG_COUNT;

  // Instruction latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      instr_r <= in_word;
    end
  end

  // Single write port: destination, or source for the second xchg write
  assign wr_en   = (cmd.wr_dest & wr_d_in) | (cmd.wr_src & wr_s_in);
  assign wr_addr = cmd.wr_src ? wr_s_addr : wr_d_addr;
  assign wr_data = cmd.wr_src ? a : res_r;

  // Memory: one write, two registered reads at accept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.load) begin
      rd_a_r <= rf_mem_r[rd_d_addr];
      rd_b_r <= rf_mem_r[rd_s_addr];
    end
  end

  // Valid bits: a never-written entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.load) begin
        va_r <= rd_d_in && vld_r[rd_d_addr];
        vb_r <= rd_s_in && vld_r[rd_s_addr];
      end
    end
  end

  assign a = va_r ? rd_a_r : '0;
  assign b = vb_r ? rd_b_r : '0;

  // ALU
  always_comb begin
    case (instr_r.req_type)
      OP_IN:   alu_nxt = instr_r.immediate;
      OP_MOV:  alu_nxt = b;
      OP_XCHG: alu_nxt = b;
      OP_ADD:  alu_nxt = a + b;
      OP_SUB:  alu_nxt = a - b;
      OP_MUL:  alu_nxt = a * b;
      OP_AND:  alu_nxt = a & b;
      OP_OR:   alu_nxt = a | b;
      OP_XOR:  alu_nxt = a ^ b;
      default: alu_nxt = a;
    endcase
  end

  // Shared divider for div and mod
  rmas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .want_mod (instr_r.req_type == OP_MOD),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .result   (div_result)
  );

  // Result register ahead of the write-back
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= alu_nxt;
    end else if (cmd.div_take) begin
      res_r <= div_result;
    end
  end

  // Output word, strobed for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_out | cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_out | cmd.emit_err) begin
      out_word_r.out_value   <= cmd.emit_out ? a : '0;
      out_word_r.div_by_zero <= cmd.emit_err;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign sts.op       = instr_r.req_type;
  assign sts.b_zero   = (b == '0);
  assign sts.div_done = div_done;

endmodule

### src/rmas_ctrl.sv
// Controller: sequences accept, execute, divide wait and write-back.
module rmas_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  rmas_pkg::dp_status_t  sts,
  output logic                  busy,
  output rmas_pkg::ctrl_cmd_t   cmd
);
  import rmas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIVW = 5'b00100,
    S_WR   = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          OP_IN, OP_MOV, OP_XCHG, OP_ADD, OP_SUB, OP_MUL,
          OP_AND, OP_OR, OP_XOR: begin
            state_nxt = S_WR;
          end
          OP_OUT: begin
            cmd.emit_out = 1'b1;
            state_nxt    = S_IDLE;
          end
          OP_DIV, OP_MOD: begin
            if (sts.b_zero) begin
              cmd.emit_err = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVW;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_WR;
        end
      end
      S_WR: begin
        cmd.wr_dest = 1'b1;
        state_nxt   = (sts.op == OP_XCHG) ? S_WR2 : S_IDLE;
      end
      S_WR2: begin
        cmd.wr_src = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // The second xchg write follows the destination write
  a_wr_src_after_dest: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_src |-> $past(cmd.wr_dest))
    else $error("source write without preceding destination write");

  // Execution always comes right after an accept
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.load))
    else $error("execute step without an accepted word");

  // The divider finishes only while the controller waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIVW))
    else $error("divider done outside the wait state");

endmodule

### src/register_machine_alu_step.sv
// Top level: one decoded instruction per word against a 32-bit register file.
// A word is taken when start is high and busy is low; busy stays high until write-back ends.
// Per word: out and a zero divisor return straight to idle; in/mov/alu ops write once; xchg
// writes twice on one memory write port; div/mod wait for the radix-2 divider's 32 iterations.
// Results strobe out_valid for one cycle; for out and errors it is registered from the execute state.
// Synchronous reset clears the per-register valid bits, so all registers read zero at once.
module register_machine_alu_step #(
  parameter int REG_COUNT = rmas_pkg::REG_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rmas_pkg::in_word_t  in_word,
  output logic                out_valid,
  output rmas_pkg::out_word_t out_word
);
  import rmas_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  rmas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  rmas_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### bench/tb.sv
// Self-checking bench for register_machine_alu_step: directed table, then random programs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmas_pkg::*;

  localparam int REG_COUNT   = REG_COUNT_DEF;
  localparam int RANDOM_WORDS = 1550;
  localparam int QUIET_TAIL  = 150;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [DATA_W-1:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONE = 32'hffff_ffff;

  // One directed row: the instruction and, where fixed, the result it must give
  typedef struct {
    in_word_t  instr;
    bit        fixed;
    out_word_t result;
  } plan_row_t;

  localparam out_word_t NO_RESULT = '0;
  localparam out_word_t DIV_ZERO  = {32'sd0, 1'b1};

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // Side band that travels with the driven word: a typed-in expectation
  bit        use_fixed;
  out_word_t fixed_result;

  // Shadow copy of the register file and the results still owed by the block
  logic [DATA_W-1:0] arch_regs [REG_COUNT];
  out_word_t         pending_results [$];

  int mismatches;
  int words_sent;
  int results_seen;
  int div_zero_seen;

  out_word_t predicted;
  out_word_t wanted;

  plan_row_t directed [26] = '{
    '{{OP_OUT,  5'd0,  5'd0,  32'sd0},  1'b1, {32'sd0, 1'b0}},
    '{{OP_IN,   5'd1,  5'd0,  INT_MAX}, 1'b0, NO_RESULT},
    '{{OP_IN,   5'd2,  5'd0,  INT_MIN}, 1'b0, NO_RESULT},
    '{{OP_IN,   5'd31, 5'd31, ALL_ONE}, 1'b0, NO_RESULT},
    '{{OP_OUT,  5'd1,  5'd0,  32'sd0},  1'b1, {INT_MAX, 1'b0}},
    '{{OP_OUT,  5'd2,  5'd0,  32'sd0},  1'b1, {INT_MIN, 1'b0}},
    '{{OP_DIV,  5'd1,  5'd3,  32'sd0},  1'b1, DIV_ZERO},
    '{{OP_MOD,  5'd2,  5'd0,  32'sd0},  1'b1, DIV_ZERO},
    '{{OP_DIV,  5'd2,  5'd31, 32'sd0},  1'b0, NO_RESULT},
    '{{OP_OUT,  5'd2,  5'd0,  32'sd0},  1'b1, {INT_MIN, 1'b0}},
    '{{OP_MOD,  5'd2,  5'd31, 32'sd0},  1'b0, NO_RESULT},
    '{{OP_OUT,  5'd2,  5'd0,  32'sd0},  1'b1, {32'sd0, 1'b0}},
    '{{OP_IN,   5'd2,  5'd0,  INT_MIN}, 1'b0, NO_RESULT},
    '{{OP_ADD,  5'd1,  5'd1,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_SUB,  5'd1,  5'd2,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_MUL,  5'd2,  5'd31, 32'sd0},  1'b0, NO_RESULT},
    '{{OP_MOV,  5'd5,  5'd1,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_XCHG, 5'd5,  5'd31, 32'sd0},  1'b0, NO_RESULT},
    '{{OP_XCHG, 5'd3,  5'd3,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_AND,  5'd5,  5'd1,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_OR,   5'd6,  5'd2,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_XOR,  5'd1,  5'd1,  32'sd0},  1'b0, NO_RESULT},
    '{{4'd15,   5'd30, 5'd29, ALL_ONE}, 1'b0, NO_RESULT},
    '{{OP_DIV,  5'd31, 5'd2,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_OUT,  5'd31, 5'd0,  32'sd0},  1'b0, NO_RESULT},
    '{{OP_OUT,  5'd5,  5'd0,  32'sd0},  1'b0, NO_RESULT}
  };

  register_machine_alu_step #(.REG_COUNT(REG_COUNT)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void write_reg(input int idx, input logic [DATA_W-1:0] val);
    if (idx < REG_COUNT) arch_regs[idx] = val;
  endfunction

  // Execute one instruction on the shadow registers; returns 1 if it yields a result
  function automatic bit execute_instr(input in_word_t w, output out_word_t res);
    logic [DATA_W-1:0] a, b, ma, mb, quo, rem;
    bit                na, nb;
    int                d, s;
    d   = w.dest_index;
    s   = w.src_index;
    a   = (d < REG_COUNT) ? arch_regs[d] : '0;
    b   = (s < REG_COUNT) ? arch_regs[s] : '0;
    res = '0;
    execute_instr = 1'b0;
    case (w.req_type)
      OP_IN:   write_reg(d, w.immediate);
      OP_OUT: begin
        res.out_value = a;
        execute_instr = 1'b1;
      end
      OP_MOV:  write_reg(d, b);
      OP_XCHG: begin
        write_reg(d, b);
        write_reg(s, a);
      end
      OP_ADD:  write_reg(d, a + b);
      OP_SUB:  write_reg(d, a - b);
      OP_MUL:  write_reg(d, a * b);
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          res.div_by_zero = 1'b1;
          execute_instr = 1'b1;
        end else begin
          // magnitude divide, then fix signs: truncation toward zero
          na  = a[DATA_W-1];
          nb  = b[DATA_W-1];
          ma  = na ? -a : a;
          mb  = nb ? -b : b;
          quo = ma / mb;
          rem = ma % mb;
          if (w.req_type == OP_MOD) write_reg(d, na ? -rem : rem);
          else                      write_reg(d, (na != nb) ? -quo : quo);
        end
      end
      OP_AND:  write_reg(d, a & b);
      OP_OR:   write_reg(d, a | b);
      OP_XOR:  write_reg(d, a ^ b);
      default: ;
    endcase
  endfunction

  // Random instruction: mostly small register windows so values flow between ops
  function automatic in_word_t random_instr();
    in_word_t w;
    int       sel;
    sel = $urandom_range(0, 99);
    if (sel < 18)      w.req_type = OP_IN;
    else if (sel < 33) w.req_type = OP_OUT;
    else if (sel < 37) w.req_type = 4'($urandom_range(12, 15));
    else               w.req_type = 4'($urandom_range(OP_MOV, OP_XOR));
    w.dest_index = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 7));
    w.src_index  = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       w.immediate = '0;
      1:       w.immediate = INT_MIN;
      2:       w.immediate = INT_MAX;
      3:       w.immediate = ALL_ONE;
      4:       w.immediate = 32'($urandom_range(0, 16)) - 32'd8;
      default: w.immediate = $urandom;
    endcase
    return w;
  endfunction

  // Present one word from a falling edge and hold it until the block takes it
  task automatic issue(input in_word_t w, input bit fixed, input out_word_t fx,
                       input bit idle_on);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    start        <= 1'b1;
    in_word      <= w;
    use_fixed    <= fixed;
    fixed_result <= fx;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Result check first, then prediction of the word taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (out_word.div_by_zero) div_zero_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word value=%h dz=%b",
                   $time, out_word.out_value, out_word.div_by_zero);
        end else begin
          wanted = pending_results.pop_front();
          if (out_word.out_value !== wanted.out_value ||
              out_word.div_by_zero !== wanted.div_by_zero) begin
            mismatches++;
            $display("%0t: result mismatch expected value=%h dz=%b actual value=%h dz=%b",
                     $time, wanted.out_value, wanted.div_by_zero,
                     out_word.out_value, out_word.div_by_zero);
          end
        end
      end
      if (start && !busy) begin
        words_sent++;
        if (execute_instr(in_word, predicted))
          pending_results.push_back(use_fixed ? fixed_result : predicted);
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    use_fixed    = 1'b0;
    fixed_result = '0;
    mismatches    = 0;
    words_sent    = 0;
    results_seen  = 0;
    div_zero_seen = 0;
    for (int i = 0; i < REG_COUNT; i++) arch_regs[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (directed[i])
      issue(directed[i].instr, directed[i].fixed, directed[i].result, 1'b1);

    // Random programs: idle stretches alternate with back-to-back runs, quiet tail
    for (int i = 0; i < RANDOM_WORDS; i++)
      issue(random_instr(), 1'b0, NO_RESULT,
            (i < RANDOM_WORDS - QUIET_TAIL) && ((i / 100) % 2 == 0));
    start <= 1'b0;

    // Drain: owed results first, then room for a trailing divide
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instruction words over all twelve ops and unused opcodes;", words_sent);
    $display("checked %0d result words, %0d of them zero-divisor errors.",
             results_seen, div_zero_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
